// File: rtl/pfcd_pkg.sv
// Package for the PCM format converter / downmix block.
// Types and constants shared by the modules; no dependencies.
`default_nettype none
package pfcd_pkg;
  localparam int QW = 40;
  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [2:0] {
    FMT_IN_U8 = 3'd0, FMT_IN_S16 = 3'd1, FMT_IN_S24 = 3'd2,
    FMT_IN_S32 = 3'd3, FMT_IN_F32 = 3'd4
  } in_fmt_t;

  typedef enum logic [1:0] {
    FMT_OUT_S16 = 2'd0, FMT_OUT_S24 = 2'd1, FMT_OUT_S32 = 2'd2, FMT_OUT_F32 = 2'd3
  } out_fmt_t;

  localparam logic [1:0] CFG_IN_CH  = 2'd0;
  localparam logic [1:0] CFG_OUT_CH = 2'd1;
  localparam logic [1:0] CFG_IN_FMT = 2'd2;
  localparam logic [1:0] CFG_OUT_FMT = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_READ, ST_ENC, ST_NORM, ST_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] sample;
    logic [2:0]  channel;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

// File: rtl/pfcd_if.sv
// Valid/ready channel interface with a generic payload.
// Depends on nothing; payload width is a parameter.
`default_nettype none
interface pfcd_if #(parameter int W = 32) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/pfcd_in_conv.sv
// Input sample normalization to Q8.31 (combinational).
// Depends on pfcd_pkg.
`default_nettype none
module pfcd_in_conv (
  input  wire logic [2:0]  fmt,
  input  wire logic [31:0] raw,
  output pfcd_pkg::q_t     q
);
  import pfcd_pkg::*;
  logic [7:0]  e;
  logic [39:0] full, mag;
  logic        neg;
  always_comb begin
    e    = raw[30:23];
    neg  = raw[31];
    full = {16'd0, 1'b1, raw[22:0]};
    mag  = '0;
    q    = '0;
    unique case (fmt)
      FMT_IN_U8:  q = {{8{~raw[7]}}, ~raw[7], raw[6:0], 24'd0};
      FMT_IN_S16: q = {{8{raw[15]}}, raw[15:0], 16'd0};
      FMT_IN_S24: q = {{8{raw[23]}}, raw[23:0], 8'd0};
      FMT_IN_S32: q = {{8{raw[31]}}, raw};
      FMT_IN_F32: begin
        if (e == 8'd255) mag = (raw[22:0] != 0) ? 40'd0 : 40'h80_0000_0000;
        else if (e == 8'd0) mag = '0;
        else if (e >= 8'd135) mag = 40'h80_0000_0000;
        else if (e >= 8'd119) mag = full << (e - 8'd119);
        else if (8'd119 - e >= 8'd24) mag = '0;
        else mag = full >> (8'd119 - e);
        if (e == 8'd255 && raw[22:0] != 0) q = '0;
        else if (neg) q = mag[39] ? 40'h80_0000_0000 : -mag;
        else q = mag[39] ? 40'h7F_FFFF_FFFF : mag;
      end
      default: q = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/pfcd_core.sv
// Frame store memory, sequencer, downmix divider and output encoder.
// Depends on pfcd_pkg.
`default_nettype none
module pfcd_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [3:0]  num_in_ch,
  input  wire logic [3:0]  num_out_ch,
  input  wire logic [1:0]  out_format,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pfcd_pkg::q_t in_q,
  output logic             res_valid,
  input  wire logic        res_ready,
  output pfcd_pkg::res_t   res
);
  import pfcd_pkg::*;
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = $clog2(MAX_CHANNELS + 1);
  localparam int SW = QW + CW + 1;

  // frame store: one write, one registered read
  q_t          mem [MAX_CHANNELS];
  q_t          rd_r;
  logic        we;
  logic [AW-1:0] wa, ra;
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= in_q;
    rd_r <= mem[ra];
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, ch_r, ch_nxt, k_r, k_nxt, nin, nout;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [SW-1:0] dq_r, dq_nxt, drem_r, drem_nxt, rtmp;
  logic [6:0]    dstep_r, dstep_nxt;
  logic          dneg_r, dneg_nxt;
  q_t            val_r, val_nxt, avg_r, avg_nxt;
  logic          have_avg_r, have_avg_nxt;
  logic [31:0]   o_r, o_nxt;
  logic          ov_r, ov_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic [5:0]    p_r, p_nxt;
  logic [39:0]   mag_r, mag_nxt;
  logic          acc;

  always_comb begin
    nin  = (num_in_ch == 0) ? CW'(1) :
           (32'(num_in_ch) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(num_in_ch);
    nout = (num_out_ch == 0) ? CW'(1) :
           (32'(num_out_ch) > MAX_CHANNELS) ? CW'(MAX_CHANNELS) : CW'(num_out_ch);
  end

  assign in_ready  = (state_r == ST_IDLE) && !ov_r;
  assign acc       = in_valid && in_ready;
  assign we        = acc && (cnt_r < CW'(MAX_CHANNELS));
  assign wa        = cnt_r[AW-1:0];
  assign res_valid = ov_r;

  // read address selection
  always_comb begin
    ra = ch_r[AW-1:0];
    if (state_r == ST_SUM) ra = k_r[AW-1:0];
    else if (ch_r >= nin) ra = '0;
  end

  logic signed [63:0] cm;
  logic signed [40:0] cl;
  logic [39:0] mg;
  logic [5:0] pp;
  logic [63:0] mant, rem, half;
  logic [5:0] r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ch_nxt = ch_r; k_nxt = k_r;
    sum_nxt = sum_r; dq_nxt = dq_r; drem_nxt = drem_r; dstep_nxt = dstep_r;
    dneg_nxt = dneg_r; val_nxt = val_r; avg_nxt = avg_r; have_avg_nxt = have_avg_r;
    o_nxt = o_r; ov_nxt = ov_r; prod_nxt = prod_r; p_nxt = p_r; mag_nxt = mag_r;
    rtmp = '0; cm = '0; cl = '0; mg = '0; pp = '0; mant = '0; rem = '0; half = '0; r = '0;
    if (ov_r && res_ready) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: if (acc) begin
        if (cnt_r + CW'(1) >= nin) begin
          cnt_nxt = '0; ch_nxt = '0; have_avg_nxt = 1'b0; state_nxt = ST_READ;
        end else cnt_nxt = cnt_r + CW'(1);
      end
      ST_READ: begin
        // memory read of current channel, start of sum, or reuse of the stored average
        if (ch_r >= nin && nin != CW'(1)) begin
          if (have_avg_r) begin
            val_nxt = avg_r; state_nxt = ST_ENC;
          end else begin
            k_nxt = '0; sum_nxt = '0; state_nxt = ST_SUM;
          end
        end else state_nxt = ST_NORM;
      end
      ST_NORM: begin
        val_nxt = rd_r; state_nxt = ST_ENC;
      end
      ST_SUM: begin
        // k_r addresses; accumulate the word read on the previous cycle
        if (k_r != 0) sum_nxt = sum_r + SW'(rd_r);
        if (k_r == nin) begin
          dneg_nxt = sum_nxt[SW-1];
          dq_nxt = sum_nxt[SW-1] ? SW'(-sum_nxt) : SW'(sum_nxt);
          drem_nxt = '0; dstep_nxt = 7'(SW); state_nxt = ST_DIV;
        end else k_nxt = k_r + CW'(1);
      end
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        rtmp = {drem_r[SW-2:0], dq_r[SW-1]};
        dq_nxt = {dq_r[SW-2:0], 1'b0};
        if (rtmp >= SW'(nin)) begin
          rtmp = rtmp - SW'(nin); dq_nxt[0] = 1'b1;
        end
        drem_nxt = rtmp;
        dstep_nxt = dstep_r - 7'd1;
        if (dstep_r == 7'd1) begin
          avg_nxt = dneg_r ? QW'(-dq_nxt) : QW'(dq_nxt);
          val_nxt = avg_nxt; have_avg_nxt = 1'b1; state_nxt = ST_ENC;
        end
      end
      ST_ENC: begin
        // clip and scale, or locate leading one for float
        cl = (val_r > 40'sh00_8000_0000) ? 41'sh0_8000_0000 :
             (val_r < -40'sh00_8000_0000) ? -41'sh0_8000_0000 : 41'(val_r);
        unique case (out_format)
          FMT_OUT_S16: cm = 64'(cl) * 64'sd32767;
          FMT_OUT_S24: cm = 64'(cl) * 64'sd8388607;
          default:     cm = 64'(cl) * 64'sd2147483647;
        endcase
        prod_nxt = cm;
        mg = val_r[39] ? -val_r : val_r;
        for (int i = 0; i < 40; i++) if (mg[i]) pp = 6'(i);
        p_nxt = pp; mag_nxt = mg;
        state_nxt = ST_OUT;
      end
      ST_OUT: if (!ov_r || res_ready) begin
        cm = prod_r;
        cm = (cm < 0) ? -((-cm) >>> 31) : (cm >>> 31);
        unique case (out_format)
          FMT_OUT_S16: o_nxt = {16'd0, cm[15:0]};
          FMT_OUT_S24: o_nxt = {8'd0, cm[23:0]};
          FMT_OUT_S32: o_nxt = cm[31:0];
          default: begin
            if (mag_r == 0) o_nxt = '0;
            else begin
              pp = p_r;
              if (p_r <= 6'd23) mant = 64'(mag_r) << (6'd23 - p_r);
              else begin
                r = p_r - 6'd23;
                mant = 64'(mag_r) >> r;
                rem = 64'(mag_r) & ((64'd1 << r) - 64'd1);
                half = 64'd1 << (r - 6'd1);
                if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
                if (mant[24]) begin mant = mant >> 1; pp = pp + 6'd1; end
              end
              o_nxt = {val_r[39], 8'(pp) + 8'd96, mant[22:0]};
            end
          end
        endcase
        ov_nxt = 1'b1;
        if (ch_r + CW'(1) >= nout) state_nxt = ST_IDLE;
        else state_nxt = ST_READ;
        ch_nxt = ch_r + CW'(1);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [2:0] oc_r, oc_nxt;
  logic       ol_r, ol_nxt;
  always_comb begin
    oc_nxt = oc_r; ol_nxt = ol_r;
    if (state_r == ST_OUT && (!ov_r || res_ready)) begin
      oc_nxt = 3'(ch_r); ol_nxt = (ch_r + CW'(1) >= nout);
    end
  end
  assign res = '{sample: o_r, channel: oc_r, last: ol_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; cnt_r <= '0; ch_r <= '0; ov_r <= 1'b0; have_avg_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ch_r <= ch_nxt; ov_r <= ov_nxt;
      have_avg_r <= have_avg_nxt;
    end
    k_r <= k_nxt; sum_r <= sum_nxt; dq_r <= dq_nxt; drem_r <= drem_nxt;
    dstep_r <= dstep_nxt; dneg_r <= dneg_nxt; val_r <= val_nxt; avg_r <= avg_nxt;
    o_r <= o_nxt; prod_r <= prod_nxt; p_r <= p_nxt; mag_r <= mag_nxt;
    oc_r <= oc_nxt; ol_r <= ol_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/pcm_format_convert_downmix.sv
// PCM format converter with channel up/down-mix, top level.
// Channels: in (sample_bits) and out (sample, channel, last) valid/ready
// interfaces; plain config write port. Each input sample is normalized to
// Q8.31 and written to an 8-entry frame store. When the frame is complete
// the sequencer reads the store and emits one item per output channel.
// Sequence: a sample that does not complete its frame is only stored. A
// completing sample starts the sequencer: a channel copied from the store
// goes through read, load, encode and output. The first average channel
// goes through read, accumulation of the N input channels, the restoring
// divider, encode and output; later average channels reuse the quotient
// and go through read, encode and output. No new sample is taken while a
// frame is being emitted or while the output register still holds an item.
// Reset: config returns to 2 ch in, 2 ch out, s16 in, s16 out; the frame
// count clears; store contents are undefined until written.
// Stall: the output register holds its item while out_ready is low and the
// sequencer waits on it.
`default_nettype none
module pcm_format_convert_downmix #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pfcd_if.sink             in_if,
  pfcd_if.source           out_if,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  import pfcd_pkg::*;
  logic [3:0] in_ch_r, out_ch_r;
  logic [2:0] in_fmt_r;
  logic [1:0] out_fmt_r;
  q_t q;
  res_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r <= 4'd2; out_ch_r <= 4'd2; in_fmt_r <= FMT_IN_S16; out_fmt_r <= FMT_OUT_S16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_CH:   in_ch_r <= cfg_data;
        CFG_OUT_CH:  out_ch_r <= cfg_data;
        CFG_IN_FMT:  in_fmt_r <= cfg_data[2:0];
        CFG_OUT_FMT: out_fmt_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  pfcd_in_conv u_conv (.fmt(in_fmt_r), .raw(in_if.data[31:0]), .q(q));

  pfcd_core #(.MAX_CHANNELS(MAX_CHANNELS)) u_core (
    .clk(clk), .rst_n(rst_n), .num_in_ch(in_ch_r), .num_out_ch(out_ch_r),
    .out_format(out_fmt_r), .in_valid(in_if.valid), .in_ready(in_if.ready), .in_q(q),
    .res_valid(out_if.valid), .res_ready(out_if.ready), .res(res)
  );
  assign out_if.data = res;
endmodule
`default_nettype wire

// File: tb/pfcd_checker.sv
`timescale 1ns / 100ps
// Prediction and checking for the PCM format converter / downmix block.
// Watches the input, result and register-write ports; depends on pfcd_pkg and pfcd_if.
module pfcd_checker (
  input  logic       clk,
  input  logic       rst_n,
  pfcd_if            in_if,
  pfcd_if            out_if,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output int         results_seen
);
  import pfcd_pkg::*;

  localparam longint Q_ONE   = 64'sd1 << 31;
  localparam longint Q_SAT   = 64'sd1 << 39;
  localparam longint Q_MAX   = (64'sd1 << 39) - 1;
  localparam int     NCH_MAX = 8;

  // predictor state and register copy
  longint     frame_q [NCH_MAX];
  int         held;
  logic [3:0] in_ch, out_ch;
  logic [2:0] in_fmt;
  logic [1:0] out_fmt;
  res_t       sample_queue [$];

  function automatic int clamp_ch(logic [3:0] n);
    if (n == 0) return 1;
    return (n > NCH_MAX) ? NCH_MAX : int'(n);
  endfunction

  // float32 to Q8.31, truncating and saturating
  function automatic longint float_to_q31(logic [31:0] b);
    int     e;
    longint m, full, mag;
    e = b[30:23];
    m = b[22:0];
    if (e == 255) begin
      if (m != 0) return 0;
      mag = Q_SAT;
    end else if (e == 0) begin
      mag = 0;
    end else begin
      full = m | 64'h800000;
      if (e >= 135) mag = Q_SAT;
      else if (e >= 119) mag = full << (e - 119);
      else if (119 - e >= 24) mag = 0;
      else mag = full >> (119 - e);
    end
    if (b[31]) return (mag >= Q_SAT) ? -Q_SAT : -mag;
    return (mag > Q_MAX) ? Q_MAX : mag;
  endfunction

  // Q8.31 to float32, round to nearest even
  function automatic logic [31:0] q31_to_float(longint v);
    logic [31:0]     sgn;
    longint unsigned mag, mant, rem, half;
    int              p, r;
    sgn = (v < 0) ? 32'h8000_0000 : 32'h0;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    if (mag == 0) return 32'h0;
    p = 0;
    while (p < 63 && (mag >> (p + 1)) != 0) p++;
    if (p <= 23) begin
      mant = mag << (23 - p);
    end else begin
      r = p - 23;
      mant = mag >> r;
      rem = mag & ((64'd1 << r) - 1);
      half = 64'd1 << (r - 1);
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant >>= 1;
        p++;
      end
    end
    return sgn | (32'(p + 96) << 23) | 32'(mant & 64'h7F_FFFF);
  endfunction

  function automatic longint normalize(logic [31:0] raw);
    case (in_fmt)
      FMT_IN_U8:  return (longint'(raw[7:0]) - 128) * 64'sd16777216;
      FMT_IN_S16: return longint'($signed(raw[15:0])) * 64'sd65536;
      FMT_IN_S24: return longint'($signed(raw[23:0])) * 64'sd256;
      FMT_IN_S32: return longint'($signed(raw));
      FMT_IN_F32: return float_to_q31(raw);
      default:    return 0;
    endcase
  endfunction

  function automatic logic [31:0] encode_sample(longint v);
    longint c;
    if (out_fmt == FMT_OUT_F32) return q31_to_float(v);
    c = (v > Q_ONE) ? Q_ONE : (v < -Q_ONE) ? -Q_ONE : v;
    case (out_fmt)
      FMT_OUT_S16: return 32'((c * 32767) / Q_ONE) & 32'hFFFF;
      FMT_OUT_S24: return 32'((c * 8388607) / Q_ONE) & 32'hFF_FFFF;
      default:     return 32'((c * 2147483647) / Q_ONE);
    endcase
  endfunction

  // takes one sample; pushes a frame's results when it completes
  task automatic take_sample(logic [31:0] raw);
    int     nin, nout;
    longint s, sum;
    nin = clamp_ch(in_ch);
    nout = clamp_ch(out_ch);
    if (held < NCH_MAX) frame_q[held] = normalize(raw);
    held++;
    if (held < nin) return;
    held = 0;
    for (int ch = 0; ch < nout; ch++) begin
      if (ch < nin) begin
        s = frame_q[ch];
      end else if (nin == 1) begin
        s = frame_q[0];
      end else begin
        sum = 0;
        for (int k = 0; k < nin; k++) sum += frame_q[k];
        s = sum / nin;
      end
      sample_queue.push_back('{sample: encode_sample(s), channel: 3'(ch),
                               last: (ch + 1 == nout)});
    end
  endtask

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      held <= 0;
      in_ch <= 4'd2;
      out_ch <= 4'd2;
      in_fmt <= FMT_IN_S16;
      out_fmt <= FMT_OUT_S16;
      for (int i = 0; i < NCH_MAX; i++) frame_q[i] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IN_CH:   in_ch = cfg_data;
          CFG_OUT_CH:  out_ch = cfg_data;
          CFG_IN_FMT:  in_fmt = cfg_data[2:0];
          CFG_OUT_FMT: out_fmt = cfg_data[1:0];
        endcase
      end
      if (in_if.valid && in_if.ready) take_sample(in_if.data);
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        results_seen++;
        if (sample_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item %h (no result pending)", $time, got);
        end else begin
          want = sample_queue.pop_front();
          if (got.sample !== want.sample) begin
            fail_count++;
            $display("%0t: sample expected %h actual %h", $time, want.sample, got.sample);
          end
          if (got.channel !== want.channel) begin
            fail_count++;
            $display("%0t: channel expected %0d actual %0d", $time,
                     want.channel, got.channel);
          end
          if (got.last !== want.last) begin
            fail_count++;
            $display("%0t: frame_last expected %b actual %b", $time, want.last, got.last);
          end
        end
      end
    end
    pending = sample_queue.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
    held = 0;
  end
endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench: clock, reset, stimulus, result back-pressure and verdict.
// Depends on pfcd_pkg, pfcd_if, pfcd_checker and the pcm_format_convert_downmix block.
module testbench;
  import pfcd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_IN_CH;
  logic [3:0] cfg_data = 4'd0;
  int         fail_count, pending, results_seen;
  int         n_sent = 0;
  int         idle_cycles = 0;
  bit         no_gaps = 1'b0;

  pfcd_if #(.W(32))         in_ch (clk);
  pfcd_if #(.W($bits(res_t))) out_ch (clk);

  pcm_format_convert_downmix dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pfcd_checker chk (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // all four registers, one per cycle; called with the block idle
  task automatic write_regs(logic [3:0] nin, logic [3:0] nout, logic [2:0] fin,
                            logic [1:0] fout);
    logic [1:0] idx [4];
    logic [3:0] val [4];
    idx = '{CFG_IN_CH, CFG_OUT_CH, CFG_IN_FMT, CFG_OUT_FMT};
    val = '{nin, nout, 4'(fin), 4'(fout)};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain all results, then let a partial frame's work settle
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_sample(logic [31:0] bits);
    int gap, r;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    r = $urandom_range(0, 9);
    gap = (no_gaps || r < 7) ? 0 : (r < 9) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_sample(logic [2:0] fmt);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
        default: return 32'h7FFF_FFFF >> (8 * $urandom_range(0, 3));
      endcase
    end
    // floats mostly near the useful exponent range
    if (fmt == FMT_IN_F32 && r < 8)
      return {1'($urandom), 8'($urandom_range(100, 140)), 23'($urandom)};
    return $urandom;
  endfunction

  // result side: random stalls, one long hold-off once the input is busy
  initial begin
    int stall_left, run_left;
    bit held_off;
    stall_left = 0;
    run_left = 0;
    held_off = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && n_sent >= 60) begin
        held_off = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ch.ready <= 1'b1;
        run_left--;
      end else begin
        run_left = $urandom_range(0, 19);
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 3);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item and no register write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d idle cycles, %0d results still pending", idle_cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [3:0] nin, nout;
    logic [2:0] fin;
    logic [1:0] fout;
    int         n;
    in_ch.valid = 1'b0;
    in_ch.data = 32'h0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed: mono in, every input format at its extremes
    write_regs(4'd1, 4'd2, FMT_IN_U8, FMT_OUT_S16);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0080);
    settle();
    write_regs(4'd1, 4'd1, FMT_IN_S16, FMT_OUT_S24);
    send_sample(32'h0000_8000);
    send_sample(32'hFFFF_7FFF);
    settle();
    write_regs(4'd1, 4'd3, FMT_IN_S24, FMT_OUT_S32);
    send_sample(32'h0080_0000);
    send_sample(32'h007F_FFFF);
    settle();
    write_regs(4'd1, 4'd1, FMT_IN_S32, FMT_OUT_S16);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    settle();
    // float specials: NaN, infinities, subnormal, in-range and saturating values
    write_regs(4'd1, 4'd1, FMT_IN_F32, FMT_OUT_F32);
    send_sample(32'h7FC0_0000);
    send_sample(32'h7F80_0000);
    send_sample(32'hFF80_0000);
    send_sample(32'h0000_0001);
    send_sample(32'h3F80_0000);
    send_sample(32'hBF00_0000);
    send_sample(32'h4380_0000);
    settle();
    // unknown input format gives silence; up-mix of three into six
    write_regs(4'd3, 4'd6, 3'd5, FMT_OUT_S32);
    send_sample(32'h1234_5678);
    send_sample(32'h8765_4321);
    send_sample(32'hFFFF_FFFF);
    settle();

    // random phases; channel counts span 0 and values above eight
    for (int ph = 0; ph < 12; ph++) begin
      nin = $urandom_range(0, 15);
      nout = $urandom_range(0, 15);
      fin = $urandom_range(0, 7);
      fout = $urandom_range(0, 3);
      if (ph == 0) begin
        nin = 4'd8;
        nout = 4'd8;
      end else if (ph == 1) begin
        nin = 4'd1;
        nout = 4'd8;
      end else if (ph == 2) begin
        nin = 4'd15;
        nout = 4'd0;
      end
      if (ph < 4) fout = 2'(ph);
      if (ph < 5) fin = 3'(ph);
      no_gaps = ($urandom_range(0, 3) == 0);
      write_regs(nin, nout, fin, fout);
      n = $urandom_range(18, 36);
      repeat (n) send_sample(pick_sample(fin));
      settle();
    end

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("covered %0d input samples over 18 register settings, %0d results checked",
             n_sent, results_seen);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
